FILE: design/assert_macros.svh
// Assertion macros shared by the alarm code entry RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked out of reset.
`define ACEC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication, checked out of reset.
`define ACEC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

FILE: design/acec_pkg.sv
// Package for the alarm code entry controller: request and result types,
// config register layout, register indexes and state codes. No dependencies.
package acec_pkg;

  typedef struct packed {
    logic button_edge;
    logic sensor_edge;
    logic evaluate;
  } in_t;

  typedef struct packed {
    logic [2:0] mode_now;
    logic       siren_on;
    logic [9:0] entered_code;
    logic [1:0] digit_position;
  } out_t;

  typedef struct packed {
    logic [9:0]  password;
    logic [15:0] digit_timeout;
    logic [15:0] entry_timeout;
    logic [7:0]  debounce_ticks;
  } cfg_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PASSWORD      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIGIT_TIMEOUT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_TIMEOUT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE      = 2'd3;

  localparam logic [9:0]  PASSWORD_RST      = 10'd666;
  localparam logic [15:0] DIGIT_TIMEOUT_RST = 16'd200;
  localparam logic [15:0] ENTRY_TIMEOUT_RST = 16'd1000;
  localparam logic [7:0]  DEBOUNCE_RST      = 8'd20;

  localparam logic [2:0] ST_ARMED     = 3'd0;
  localparam logic [2:0] ST_DISARMED  = 3'd1;
  localparam logic [2:0] ST_ARMING    = 3'd2;
  localparam logic [2:0] ST_DISARMING = 3'd5;

  localparam logic [3:0] DIGIT_MAX = 4'd9;

endpackage

FILE: design/acec_debounce.sv
// Edge debouncer: quiet-time counter that gates edges for one input.
// Depends on nothing but the clock and reset.
module acec_debounce (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic       edge_seen,
  input  logic [7:0] threshold,
  output logic       accept
);

  logic [7:0] quiet_r;
  logic [7:0] quiet_nxt;

  assign accept = edge_seen && (quiet_r >= threshold);

  always_comb begin
    quiet_nxt = quiet_r;
    if (step) begin
      if (accept) begin
        quiet_nxt = '0;
      end else if (quiet_r != 8'hFF) begin
        quiet_nxt = quiet_r + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quiet_r <= 8'hFF;
    end else begin
      quiet_r <= quiet_nxt;
    end
  end

endmodule

FILE: design/acec_core.sv
// Arm/disarm state machine, code digits, timers and edge flags.
// Uses acec_pkg, acec_debounce and assert_macros.svh.
`include "assert_macros.svh"

module acec_core #(
  parameter int CODE_DIGITS = 3
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  acec_pkg::in_t  req,
  input  acec_pkg::cfg_t cfg,
  output acec_pkg::out_t res
);
  import acec_pkg::*;

  localparam int IDX_W = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
  localparam int VAL_W = (4 * CODE_DIGITS > 10) ? 4 * CODE_DIGITS : 10;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CODE_DIGITS - 1);

  logic [2:0]                  state_r, state_nxt;
  logic [CODE_DIGITS-1:0][3:0] digits_r, digits_nxt;
  logic [IDX_W-1:0]            idx_r, idx_nxt;
  logic [15:0]                 digit_el_r, digit_el_nxt;
  logic [15:0]                 entry_el_r, entry_el_nxt;
  logic                        bflag_r, bflag_nxt;
  logic                        sflag_r, sflag_nxt;
  logic                        siren_r, siren_nxt;

  logic             b_acc, s_acc;
  logic             bflag, sflag;
  logic             dto, eto, last, idle, arming;
  logic             rst_d, rst_e;
  logic [VAL_W-1:0] val_cur, val_new;
  logic [1:0]       slot;
  logic [IDX_W+1:0] idx_ext;

  function automatic logic [VAL_W-1:0] code_val(input logic [CODE_DIGITS-1:0][3:0] d);
    logic [VAL_W-1:0] v;
    v = '0;
    for (int i = CODE_DIGITS - 1; i >= 0; i--) begin
      v = (v << 3) + (v << 1) + VAL_W'(d[i]);
    end
    return v;
  endfunction

  acec_debounce u_btn (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .edge_seen (req.button_edge),
    .threshold (cfg.debounce_ticks),
    .accept    (b_acc)
  );

  acec_debounce u_sns (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .edge_seen (req.sensor_edge),
    .threshold (cfg.debounce_ticks),
    .accept    (s_acc)
  );

  assign bflag   = bflag_r | b_acc;
  assign sflag   = sflag_r | s_acc;
  assign dto     = digit_el_r >= cfg.digit_timeout;
  assign eto     = entry_el_r >= cfg.entry_timeout;
  assign last    = idx_r >= LAST_IDX;
  assign idle    = (state_r == ST_ARMED) || (state_r == ST_DISARMED);
  assign arming  = state_r == ST_ARMING;
  assign val_cur = code_val(digits_r);

  always_comb begin
    state_nxt  = state_r;
    digits_nxt = digits_r;
    idx_nxt    = idx_r;
    bflag_nxt  = bflag;
    sflag_nxt  = sflag;
    siren_nxt  = siren_r;
    rst_d      = 1'b0;
    rst_e      = 1'b0;
    if (req.evaluate) begin
      if (idle) begin
        if (bflag) begin
          state_nxt = (state_r == ST_ARMED) ? ST_DISARMING : ST_ARMING;
          rst_d     = 1'b1;
          rst_e     = 1'b1;
          bflag_nxt = 1'b0;
        end else if (state_r == ST_ARMED && sflag) begin
          siren_nxt  = 1'b1;
          sflag_nxt  = 1'b0;
          digits_nxt = '0;
          idx_nxt    = '0;
        end
      end else if (!last && dto) begin
        idx_nxt = idx_r + IDX_W'(1);
        rst_d   = 1'b1;
      end else if (bflag) begin
        digits_nxt[idx_r] = (digits_r[idx_r] >= DIGIT_MAX) ? 4'd0 : digits_r[idx_r] + 4'd1;
        rst_d     = 1'b1;
        rst_e     = 1'b1;
        bflag_nxt = 1'b0;
      end else if (last && dto && val_cur == VAL_W'(cfg.password)) begin
        digits_nxt = '0;
        idx_nxt    = '0;
        rst_d      = 1'b1;
        rst_e      = 1'b1;
        if (arming) begin
          state_nxt = ST_ARMED;
        end else begin
          state_nxt = ST_DISARMED;
          siren_nxt = 1'b0;
        end
      end else if (eto) begin
        digits_nxt = '0;
        idx_nxt    = '0;
        if (arming) begin
          state_nxt = ST_DISARMED;
          siren_nxt = 1'b0;
          rst_d     = 1'b1;
          rst_e     = 1'b1;
        end else begin
          state_nxt = ST_ARMED;
          siren_nxt = 1'b1;
          sflag_nxt = 1'b0;
        end
      end
    end
  end

  always_comb begin
    if (rst_d) begin
      digit_el_nxt = '0;
    end else if (digit_el_r != 16'hFFFF) begin
      digit_el_nxt = digit_el_r + 16'd1;
    end else begin
      digit_el_nxt = digit_el_r;
    end
    if (rst_e) begin
      entry_el_nxt = '0;
    end else if (entry_el_r != 16'hFFFF) begin
      entry_el_nxt = entry_el_r + 16'd1;
    end else begin
      entry_el_nxt = entry_el_r;
    end
  end

  always_comb begin
    if (idx_nxt == '0) begin
      slot = 2'd0;
    end else if (idx_nxt >= LAST_IDX) begin
      slot = 2'd2;
    end else begin
      slot = 2'd1;
    end
  end

  assign val_new = code_val(digits_nxt);
  assign idx_ext = {2'b00, idx_nxt};

  always_comb begin
    res.mode_now = ((state_nxt == ST_ARMED) || (state_nxt == ST_DISARMED)) ?
                   state_nxt : state_nxt + {1'b0, slot};
    res.siren_on       = siren_nxt;
    res.entered_code   = val_new[9:0];
    res.digit_position = idx_ext[1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_DISARMED;
      digits_r   <= '0;
      idx_r      <= '0;
      digit_el_r <= '0;
      entry_el_r <= '0;
      bflag_r    <= 1'b0;
      sflag_r    <= 1'b0;
      siren_r    <= 1'b0;
    end else if (step) begin
      state_r    <= state_nxt;
      digits_r   <= digits_nxt;
      idx_r      <= idx_nxt;
      digit_el_r <= digit_el_nxt;
      entry_el_r <= entry_el_nxt;
      bflag_r    <= bflag_nxt;
      sflag_r    <= sflag_nxt;
      siren_r    <= siren_nxt;
    end
  end

  `ACEC_ASSERT(a_idx_bound, idx_r <= LAST_IDX, "digit index past last digit")
  `ACEC_ASSERT_IMP(a_idle_clear, idle, (idx_r == '0) && (digits_r == '0), "code kept while idle")
  `ACEC_ASSERT_IMP(a_siren_mode, siren_r,
                   (state_r == ST_ARMED) || (state_r == ST_DISARMING),
                   "siren on outside armed or disarming mode")

endmodule

FILE: design/alarm_code_entry_controller.sv
// Top level of the alarm code entry controller: request and result
// registers, config registers. Uses acec_pkg and acec_core.
//
//   channel   direction   handshake          payload
//   in_       request     in_valid/in_stall  in_data   (acec_pkg::in_t)
//   out_      result      out_valid/out_stall out_data (acec_pkg::out_t)
//   cfg_      config      cfg_valid/cfg_ready cfg_index, cfg_data
//
// One request per clock unless out_stall holds the result register: a request
// waits in the input register, and state update and result capture happen as
// it advances, raising out_valid. in_stall rises only when the input register
// is full and the result register is held by out_stall.
// Synchronous active-low reset; config registers reset to their defaults.
module alarm_code_entry_controller #(
  parameter int CODE_DIGITS = 3
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  acec_pkg::in_t                        in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output acec_pkg::out_t                       out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [acec_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [acec_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import acec_pkg::*;

  logic   s1_valid_r, s1_valid_nxt;
  in_t    s1_data_r;
  logic   out_valid_r, out_valid_nxt;
  out_t   out_data_r;
  cfg_t   cfg_r;
  out_t   res;
  logic   advance, accept_in;

  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign accept_in = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    if (accept_in) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  acec_core #(
    .CODE_DIGITS (CODE_DIGITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .req   (s1_data_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      s1_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.password       <= PASSWORD_RST;
      cfg_r.digit_timeout  <= DIGIT_TIMEOUT_RST;
      cfg_r.entry_timeout  <= ENTRY_TIMEOUT_RST;
      cfg_r.debounce_ticks <= DEBOUNCE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PASSWORD:      cfg_r.password       <= cfg_data[9:0];
        REG_DIGIT_TIMEOUT: cfg_r.digit_timeout  <= cfg_data[15:0];
        REG_ENTRY_TIMEOUT: cfg_r.entry_timeout  <= cfg_data[15:0];
        REG_DEBOUNCE:      cfg_r.debounce_ticks <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: test/tb_top.sv
// Testbench for alarm_code_entry_controller: drives tick requests through a
// randomly stalled handshake and checks every result against a local model.
// Depends on acec_pkg and the controller RTL.
module tb_top;
  import acec_pkg::*;

  localparam int NDIG = 3;
  localparam int NO_LIMIT = 1000000;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_t                   in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_t                  out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  alarm_code_entry_controller #(.CODE_DIGITS(NDIG)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Controller settings as last written
  logic [9:0]  pw_cfg       = PASSWORD_RST;
  logic [15:0] digit_limit  = DIGIT_TIMEOUT_RST;
  logic [15:0] entry_limit  = ENTRY_TIMEOUT_RST;
  logic [7:0]  debounce_cfg = DEBOUNCE_RST;

  // Controller state
  logic [2:0]  alarm_mode = ST_DISARMED;
  logic [3:0]  code_digit [NDIG] = '{default: 4'd0};
  logic [1:0]  digit_pos = 2'd0;
  int unsigned digit_age = 0;
  int unsigned entry_age = 0;
  bit          press_pending = 1'b0;
  bit          sensor_pending = 1'b0;
  int unsigned press_quiet = 255;
  int unsigned sensor_quiet = 255;
  bit          siren_q = 1'b0;

  in_t  pending_ticks [$];
  out_t expected_status [$];
  int   ticks_queued = 0;
  int   tick_limit = NO_LIMIT;
  int   ticks_accepted = 0;
  int   results_seen = 0;
  int   bad_results = 0;
  bit   tick_taken = 1'b0;
  int   burst_left = 1;
  int   gap_left = 0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;
  int   pattern_left = 0;
  stall_mode_t stall_mode = STALL_NONE;

  function automatic int code_value();
    int v;
    v = 0;
    for (int i = NDIG - 1; i >= 0; i--) v = v * 10 + code_digit[i];
    return v;
  endfunction

  function automatic void wipe_code();
    for (int i = 0; i < NDIG; i++) code_digit[i] = 4'd0;
    digit_pos = 2'd0;
  endfunction

  function automatic out_t alarm_tick(in_t t);
    bit   restart_digit;
    bit   restart_entry;
    bit   digit_due;
    bit   entry_due;
    bit   on_last;
    bit   arming;
    out_t r;
    restart_digit = 1'b0;
    restart_entry = 1'b0;
    if (t.button_edge && press_quiet >= debounce_cfg) begin
      press_pending = 1'b1;
      press_quiet = 0;
    end else if (press_quiet < 255) begin
      press_quiet++;
    end
    if (t.sensor_edge && sensor_quiet >= debounce_cfg) begin
      sensor_pending = 1'b1;
      sensor_quiet = 0;
    end else if (sensor_quiet < 255) begin
      sensor_quiet++;
    end
    if (t.evaluate) begin
      digit_due = digit_age >= digit_limit;
      entry_due = entry_age >= entry_limit;
      on_last = digit_pos >= NDIG - 1;
      arming = alarm_mode == ST_ARMING;
      if (alarm_mode == ST_ARMED || alarm_mode == ST_DISARMED) begin
        if (press_pending) begin
          alarm_mode = (alarm_mode == ST_ARMED) ? ST_DISARMING : ST_ARMING;
          restart_digit = 1'b1;
          restart_entry = 1'b1;
          press_pending = 1'b0;
        end else if (alarm_mode == ST_ARMED && sensor_pending) begin
          siren_q = 1'b1;
          sensor_pending = 1'b0;
          wipe_code();
        end
      end else if (!on_last && digit_due) begin
        digit_pos++;
        restart_digit = 1'b1;
      end else if (press_pending) begin
        code_digit[digit_pos] = (code_digit[digit_pos] >= DIGIT_MAX) ? 4'd0 :
                                code_digit[digit_pos] + 4'd1;
        restart_digit = 1'b1;
        restart_entry = 1'b1;
        press_pending = 1'b0;
      end else if (on_last && digit_due && code_value() == pw_cfg) begin
        wipe_code();
        restart_digit = 1'b1;
        restart_entry = 1'b1;
        if (arming) begin
          alarm_mode = ST_ARMED;
        end else begin
          alarm_mode = ST_DISARMED;
          siren_q = 1'b0;
        end
      end else if (entry_due) begin
        wipe_code();
        if (arming) begin
          alarm_mode = ST_DISARMED;
          siren_q = 1'b0;
          restart_digit = 1'b1;
          restart_entry = 1'b1;
        end else begin
          alarm_mode = ST_ARMED;
          siren_q = 1'b1;
          sensor_pending = 1'b0;
        end
      end
    end
    if (restart_digit) digit_age = 0;
    else if (digit_age < 65535) digit_age++;
    if (restart_entry) entry_age = 0;
    else if (entry_age < 65535) entry_age++;
    if (alarm_mode == ST_ARMED || alarm_mode == ST_DISARMED) r.mode_now = alarm_mode;
    else if (digit_pos == 0) r.mode_now = alarm_mode;
    else if (digit_pos >= NDIG - 1) r.mode_now = alarm_mode + 3'd2;
    else r.mode_now = alarm_mode + 3'd1;
    r.siren_on = siren_q;
    r.entered_code = 10'(code_value());
    r.digit_position = digit_pos;
    return r;
  endfunction

  // Request driver: accept at rising edge, present next request at falling edge
  always @(posedge clk) begin
    tick_taken = 1'b0;
    if (rst_n && in_valid && !in_stall) begin
      expected_status.push_back(alarm_tick(in_data));
      void'(pending_ticks.pop_front());
      ticks_accepted++;
      tick_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst_n && !(in_valid && !tick_taken)) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_ticks.size() != 0) begin
        in_valid <= 1'b1;
        in_data <= pending_ticks[0];
        if (burst_left <= 1) begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150) :
                       $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result stall pattern, with one long hold-off while requests keep coming
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && ticks_accepted >= 200 && pending_ticks.size() > 30) begin
        hold_done = 1'b1;
        hold_left = 80;
        out_stall <= 1'b1;
      end else begin
        if (pattern_left == 0) begin
          stall_mode = stall_mode_t'($urandom_range(0, 3));
          pattern_left = $urandom_range(8, 80);
        end
        pattern_left--;
        case (stall_mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:     out_stall <= pattern_left[0];
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_results
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_status.size() == 0) begin
        if (bad_results < 10)
          $display("result %0d with none pending: mode %0d siren %0d code %0d pos %0d",
                   results_seen, out_data.mode_now, out_data.siren_on,
                   out_data.entered_code, out_data.digit_position);
        bad_results++;
      end else begin
        want = expected_status.pop_front();
        if (out_data.mode_now !== want.mode_now || out_data.siren_on !== want.siren_on ||
            out_data.entered_code !== want.entered_code ||
            out_data.digit_position !== want.digit_position) begin
          if (bad_results < 10)
            $display("result %0d: mode %0d/%0d siren %0d/%0d code %0d/%0d pos %0d/%0d",
                     results_seen, out_data.mode_now, want.mode_now, out_data.siren_on,
                     want.siren_on, out_data.entered_code, want.entered_code,
                     out_data.digit_position, want.digit_position);
          bad_results++;
        end
      end
      results_seen++;
    end
  end

  function automatic int capped(input int n);
    return (n > 60) ? 60 : n;
  endfunction

  task automatic add_tick(input bit b, input bit s, input bit e);
    in_t t;
    if (ticks_queued < tick_limit) begin
      t.button_edge = b;
      t.sensor_edge = s;
      t.evaluate = e;
      pending_ticks.push_back(t);
      ticks_queued++;
    end
  endtask

  task automatic quiet_ticks(input int n);
    repeat (n) add_tick(1'b0, $urandom_range(0, 23) == 0, $urandom_range(0, 11) != 0);
  endtask

  task automatic key_code(input int value);
    int spacing;
    int place;
    spacing = capped(debounce_cfg) + $urandom_range(0, 1);
    place = 1;
    add_tick(1'b1, 1'b0, 1'b1);
    quiet_ticks(spacing);
    for (int d = 0; d < NDIG; d++) begin
      repeat ((value / place) % 10) begin
        add_tick(1'b1, 1'b0, 1'b1);
        quiet_ticks(spacing);
      end
      quiet_ticks(capped(digit_limit + 1));
      place = place * 10;
    end
  endtask

  task automatic settle();
    while (pending_ticks.size() != 0 || expected_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_PASSWORD:      pw_cfg = val[9:0];
      REG_DIGIT_TIMEOUT: digit_limit = val;
      REG_ENTRY_TIMEOUT: entry_limit = val;
      REG_DEBOUNCE:      debounce_cfg = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_settings(input logic [15:0] pw, input logic [15:0] dl,
                               input logic [15:0] el, input logic [15:0] db);
    write_reg(REG_PASSWORD, pw);
    write_reg(REG_DIGIT_TIMEOUT, dl);
    write_reg(REG_ENTRY_TIMEOUT, el);
    write_reg(REG_DEBOUNCE, db);
  endtask

  task automatic exercise(input int budget);
    int first;
    int pick;
    first = ticks_queued;
    tick_limit = first + budget;
    while (ticks_queued - first < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        key_code(pw_cfg);
      end else if (pick < 55) begin
        key_code($urandom_range(0, 999));
        quiet_ticks(capped(entry_limit + 2));
      end else if (pick < 65) begin
        add_tick(1'b0, 1'b1, 1'($urandom_range(0, 1)));
        quiet_ticks($urandom_range(1, 5));
      end else if (pick < 80) begin
        repeat ($urandom_range(5, 20))
          add_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 3)) begin
          add_tick(1'b1, 1'b0, 1'b1);
          quiet_ticks(capped(debounce_cfg));
        end
        quiet_ticks(capped(entry_limit + 2));
      end else begin
        repeat ($urandom_range(4, 12))
          add_tick(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end
    tick_limit = NO_LIMIT;
    settle();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    exercise(60);

    // wrap a digit past nine, complete arming, trip the siren, start a disarm with a wrong code
    load_settings(16'd0, 16'd1, 16'd6, 16'd0);
    add_tick(1'b0, 1'b0, 1'b0);
    add_tick(1'b1, 1'b1, 1'b0);
    add_tick(1'b0, 1'b0, 1'b1);
    repeat (10) add_tick(1'b1, 1'b0, 1'b1);
    repeat (6) add_tick(1'b0, 1'b0, 1'b1);
    add_tick(1'b0, 1'b1, 1'b1);
    add_tick(1'b1, 1'b0, 1'b1);
    add_tick(1'b1, 1'b1, 1'b1);
    repeat (6) add_tick(1'b0, 1'b0, 1'b1);
    settle();

    load_settings(16'($urandom_range(0, 999)), 16'd4, 16'd30, 16'd2);
    exercise(110);
    load_settings(16'd999, 16'd3, 16'd65535, 16'd0);
    exercise(110);
    load_settings(16'hFFFF, 16'd0, 16'd1, 16'hFFFF);
    exercise(60);
    load_settings(16'($urandom_range(0, 999)), 16'd65535, 16'd20, 16'd1);
    exercise(80);
    load_settings(16'($urandom_range(0, 999)), 16'd6, 16'd40, 16'd3);
    exercise(110);
    load_settings(16'($urandom_range(0, 999)), 16'($urandom_range(2, 8)),
                  16'($urandom_range(10, 50)), 16'($urandom_range(0, 1)));
    exercise(110);

    repeat (10) @(posedge clk);
    if (expected_status.size() != 0) bad_results++;
    if (bad_results == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Verification failed");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/acec_pkg.sv
design/acec_debounce.sv
design/acec_core.sv
design/alarm_code_entry_controller.sv
test/tb_top.sv
